[src/vec3_pkg.sv]
`timescale 1ns / 1ps
// shared opcode and status codes for the vector alu
// no dependencies
package vec3_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int COMP_WIDTH_DEF = 24;
    localparam int SCALAR_W       = 50;

    typedef enum logic [2:0] {
        OP_LEN   = 3'd0,
        OP_SQLEN = 3'd1,
        OP_NORM  = 3'd2,
        OP_DOT   = 3'd3,
        OP_CROSS = 3'd4,
        OP_MADD  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

endpackage

[src/vec3_alu.sv]
`timescale 1ns / 1ps
// top level of the three-component vector alu: stream ports and the cell chains
// depends on vec3_pkg, vec3_prod, vec3_sqrt_cell, vec3_div_cell

// vec3_alu takes one transfer per clock while the output is not stalled and
// returns one result transfer per input, in order. every item walks the same
// pipeline: a register stage of six shared multipliers, a register stage of
// sums/rounding/saturation, a chain of 32+FRAC_BITS square-root cells (one
// root bit per cell), a chain of FRAC_BITS+1 divider cells (one quotient bit of
// each normalized component per cell) and the output register; the default
// format is Q8.16. components are signed fixed point with FRAC_BITS fraction
// bits; scalar results are in units of 2^-(2*FRAC_BITS). cross and multiply-add
// results round to nearest (ties up), normalized components truncate toward
// zero, and vector results clamp to the component range with status 1;
// normalizing a zero vector gives zero and status 2; opcodes six and seven
// return all zeros. a stall on the output side holds the whole pipeline, and
// s_axis_tready drops only while the output register is full and not being
// taken.
module vec3_alu
    import vec3_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // opcode, a_x, a_y, a_z, b_x, b_y, b_z, factor, zero fill
    input  logic [((3+7*COMP_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // r_x, r_y, r_z, scalar_out, status, zero fill
    output logic [((3*COMP_WIDTH+SCALAR_W+2+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW     = COMP_WIDTH;
    localparam int OUT_W  = ((3*CW+SCALAR_W+2+7)/8)*8;
    localparam int SQ_W   = 2 * CW + 1;
    localparam int STEPS  = 32 + FRAC_BITS;
    localparam int ROOT_W = STEPS;
    localparam int REM_W  = ROOT_W + 2;
    localparam int RW     = ROOT_W + 1;
    localparam int QW     = FRAC_BITS + 1;
    localparam int SIDE_W = 3 + 6 * CW + 1 + SCALAR_W;
    localparam int NW     = ((QW > CW) ? QW : CW) + 2;
    localparam logic signed [NW-1:0] MAXN = {{(NW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [NW-1:0] MINN = {{(NW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // the whole pipeline advances unless a finished result waits
    logic en;

    op_t                  in_op;
    logic signed [CW-1:0] in_a [3];
    logic signed [CW-1:0] in_b [3];
    logic signed [CW-1:0] in_f;

    logic                 f_valid;
    op_t                  f_op;
    logic signed [CW-1:0] f_a [3];
    logic signed [CW-1:0] f_vec [3];
    logic                 f_sat;
    logic [SCALAR_W-1:0]  f_scalar;
    logic [SQ_W-1:0]      f_sq;

    // square root chain taps
    logic              sq_v    [STEPS+1];
    logic [SIDE_W-1:0] sq_side [STEPS+1];
    logic [SQ_W-1:0]   sq_s    [STEPS+1];
    logic [ROOT_W-1:0] sq_root [STEPS+1];
    logic [REM_W-1:0]  sq_rem  [STEPS+1];

    // divider chain taps
    logic              dv_v    [QW+1];
    logic [SIDE_W-1:0] dv_side [QW+1];
    logic [ROOT_W-1:0] dv_len  [QW+1];
    logic [RW-1:0]     dv_r    [QW+1][3];
    logic [QW-1:0]     dv_q    [QW+1][3];

    logic [CW-1:0]        mag [3];
    logic signed [CW-1:0] mid_a [3];

    // end of chain
    op_t                  e_op;
    logic signed [CW-1:0] e_a [3];
    logic signed [CW-1:0] e_vec [3];
    logic                 e_sat;
    logic [SCALAR_W-1:0]  e_scalar;
    logic [ROOT_W-1:0]    e_len;
    logic signed [NW-1:0] nv [3];
    logic [CW-1:0]        nres [3];
    logic                 nsat [3];

    logic [CW-1:0]       rx_next, ry_next, rz_next;
    logic [SCALAR_W-1:0] scal_next;
    status_t             status_next;

    logic                out_v_reg;
    logic [CW-1:0]       rx_reg, ry_reg, rz_reg;
    logic [SCALAR_W-1:0] scal_reg;
    status_t             status_reg;

    assign en            = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    // input field unpacking
    assign in_op   = op_t'(s_axis_tdata[2:0]);
    assign in_a[0] = $signed(s_axis_tdata[3 +: CW]);
    assign in_a[1] = $signed(s_axis_tdata[3+CW +: CW]);
    assign in_a[2] = $signed(s_axis_tdata[3+2*CW +: CW]);
    assign in_b[0] = $signed(s_axis_tdata[3+3*CW +: CW]);
    assign in_b[1] = $signed(s_axis_tdata[3+4*CW +: CW]);
    assign in_b[2] = $signed(s_axis_tdata[3+5*CW +: CW]);
    assign in_f    = $signed(s_axis_tdata[3+6*CW +: CW]);

    vec3_prod #(
        .FRAC_BITS  (FRAC_BITS),
        .COMP_WIDTH (COMP_WIDTH)
    ) u_prod (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .in_op      (in_op),
        .in_a       (in_a),
        .in_b       (in_b),
        .in_f       (in_f),
        .out_valid  (f_valid),
        .out_op     (f_op),
        .out_a      (f_a),
        .out_vec    (f_vec),
        .out_sat    (f_sat),
        .out_scalar (f_scalar),
        .out_sq     (f_sq)
    );

    // side data: scalar, sat, vec x..z, a x..z, opcode from the bottom up
    assign sq_v[0]    = f_valid;
    assign sq_side[0] = {f_op, f_a[2], f_a[1], f_a[0], f_vec[2], f_vec[1], f_vec[0],
                         f_sat, f_scalar};
    assign sq_s[0]    = f_sq;
    assign sq_root[0] = '0;
    assign sq_rem[0]  = '0;

    for (genvar g = 0; g < STEPS; g++)
    begin : g_sqrt
        vec3_sqrt_cell #(
            .FRAC_BITS (FRAC_BITS),
            .SQ_W      (SQ_W),
            .ROOT_W    (ROOT_W),
            .SIDE_W    (SIDE_W),
            .STEP      (STEPS - 1 - g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[g]),
            .in_side   (sq_side[g]),
            .in_sq     (sq_s[g]),
            .in_root   (sq_root[g]),
            .in_rem    (sq_rem[g]),
            .out_valid (sq_v[g+1]),
            .out_side  (sq_side[g+1]),
            .out_sq    (sq_s[g+1]),
            .out_root  (sq_root[g+1]),
            .out_rem   (sq_rem[g+1])
        );
    end

    // magnitudes enter the divider pre-shifted; the quotient stays below 2^QW
    always_comb
    begin
        mid_a[0] = $signed(sq_side[STEPS][SCALAR_W+1+3*CW +: CW]);
        mid_a[1] = $signed(sq_side[STEPS][SCALAR_W+1+4*CW +: CW]);
        mid_a[2] = $signed(sq_side[STEPS][SCALAR_W+1+5*CW +: CW]);
        for (int k = 0; k < 3; k++)
        begin
            mag[k]      = mid_a[k][CW-1] ? CW'(-mid_a[k]) : CW'(mid_a[k]);
            dv_r[0][k]  = RW'({mag[k], {(FRAC_BITS-1){1'b0}}});
            dv_q[0][k]  = '0;
        end
    end

    assign dv_v[0]    = sq_v[STEPS];
    assign dv_side[0] = sq_side[STEPS];
    assign dv_len[0]  = sq_root[STEPS];

    for (genvar g = 0; g < QW; g++)
    begin : g_div
        vec3_div_cell #(
            .ROOT_W    (ROOT_W),
            .QW        (QW),
            .SIDE_W    (SIDE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[g]),
            .in_side   (dv_side[g]),
            .in_len    (dv_len[g]),
            .in_r      (dv_r[g]),
            .in_q      (dv_q[g]),
            .out_valid (dv_v[g+1]),
            .out_side  (dv_side[g+1]),
            .out_len   (dv_len[g+1]),
            .out_r     (dv_r[g+1]),
            .out_q     (dv_q[g+1])
        );
    end

    // result selection
    always_comb
    begin
        e_scalar = dv_side[QW][SCALAR_W-1:0];
        e_sat    = dv_side[QW][SCALAR_W];
        e_vec[0] = $signed(dv_side[QW][SCALAR_W+1 +: CW]);
        e_vec[1] = $signed(dv_side[QW][SCALAR_W+1+CW +: CW]);
        e_vec[2] = $signed(dv_side[QW][SCALAR_W+1+2*CW +: CW]);
        e_a[0]   = $signed(dv_side[QW][SCALAR_W+1+3*CW +: CW]);
        e_a[1]   = $signed(dv_side[QW][SCALAR_W+1+4*CW +: CW]);
        e_a[2]   = $signed(dv_side[QW][SCALAR_W+1+5*CW +: CW]);
        e_op     = op_t'(dv_side[QW][SIDE_W-1 -: 3]);
        e_len    = dv_len[QW];

        for (int k = 0; k < 3; k++)
        begin
            // sign of the input component goes back on the quotient
            nv[k] = e_a[k][CW-1] ? -$signed(NW'(dv_q[QW][k])) : $signed(NW'(dv_q[QW][k]));
            if (nv[k] > MAXN)
            begin
                nres[k] = MAXN[CW-1:0];
                nsat[k] = 1'b1;
            end
            else if (nv[k] < MINN)
            begin
                nres[k] = MINN[CW-1:0];
                nsat[k] = 1'b1;
            end
            else
            begin
                nres[k] = nv[k][CW-1:0];
                nsat[k] = 1'b0;
            end
        end

        rx_next     = '0;
        ry_next     = '0;
        rz_next     = '0;
        scal_next   = '0;
        status_next = ST_OK;
        case (e_op)
            OP_LEN:
                scal_next = SCALAR_W'(e_len);
            OP_SQLEN, OP_DOT:
                scal_next = e_scalar;
            OP_NORM:
            begin
                if (e_len == '0)
                    status_next = ST_ZERO;
                else
                begin
                    rx_next = nres[0];
                    ry_next = nres[1];
                    rz_next = nres[2];
                    if (nsat[0] || nsat[1] || nsat[2])
                        status_next = ST_SAT;
                end
            end
            OP_CROSS, OP_MADD:
            begin
                rx_next = e_vec[0];
                ry_next = e_vec[1];
                rz_next = e_vec[2];
                if (e_sat)
                    status_next = ST_SAT;
            end
            default:
                status_next = ST_OK;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= dv_v[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg     <= rx_next;
            ry_reg     <= ry_next;
            rz_reg     <= rz_next;
            scal_reg   <= scal_next;
            status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = OUT_W'({status_reg, scal_reg, rz_reg, ry_reg, rx_reg});

    // a zero-length normalize carries no vector and no scalar
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && status_reg == ST_ZERO) |->
        (rx_reg == '0 && ry_reg == '0 && rz_reg == '0 && scal_reg == '0))
        else $error("zero-length normalize with nonzero result");

    // saturation only comes from vector opcodes, which leave the scalar at zero
    a_sat_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && status_reg == ST_SAT) |-> (scal_reg == '0))
        else $error("saturated result with nonzero scalar");

    // the status code never takes the unused value
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg |-> (status_reg == ST_OK || status_reg == ST_SAT || status_reg == ST_ZERO))
        else $error("unused status code");

    // a result taken with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && m_axis_tready && !dv_v[QW]) |=> !out_v_reg)
        else $error("output valid without a result from the chain");

endmodule

[src/vec3_prod.sv]
`timescale 1ns / 1ps
// front end: shared multipliers, then sums, cross, multiply-add and saturation
// depends on vec3_pkg
module vec3_prod
    import vec3_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int COMP_WIDTH = COMP_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  op_t                           in_op,
    input  logic signed [COMP_WIDTH-1:0]  in_a [3],
    input  logic signed [COMP_WIDTH-1:0]  in_b [3],
    input  logic signed [COMP_WIDTH-1:0]  in_f,
    output logic                          out_valid,
    output op_t                           out_op,
    output logic signed [COMP_WIDTH-1:0]  out_a [3],
    output logic signed [COMP_WIDTH-1:0]  out_vec [3],
    output logic                          out_sat,
    output logic [SCALAR_W-1:0]           out_scalar,
    output logic [2*COMP_WIDTH:0]         out_sq
);

    localparam int CW = COMP_WIDTH;
    localparam int PW = 2 * CW;
    localparam int EW = 2 * CW + FRAC_BITS + 2;
    localparam int SQ_W = 2 * CW + 1;
    localparam logic signed [EW-1:0] MAXV = {{(EW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [EW-1:0] MINV = {{(EW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [EW-1:0] HALF =
        {{(EW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic signed [CW-1:0] ml [6];
    logic signed [CW-1:0] mr [6];

    logic                 v1_reg;
    op_t                  op1_reg;
    logic signed [CW-1:0] a1_reg [3];
    logic signed [PW-1:0] p1_reg [6];

    logic signed [EW-1:0] sum;
    logic signed [EW-1:0] pre [3];
    logic signed [EW-1:0] rnd [3];
    logic                 hi [3];
    logic                 lo [3];
    logic                 vec_op;

    logic                 v2_reg;
    op_t                  op2_reg;
    logic signed [CW-1:0] a2_reg [3];
    logic signed [CW-1:0] vec2_reg [3];
    logic                 sat2_reg;
    logic [SCALAR_W-1:0]  scal2_reg;
    logic [SQ_W-1:0]      sq2_reg;

    // operand steering for the six multipliers
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            ml[k] = '0;
            mr[k] = '0;
        end
        case (in_op)
            OP_DOT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ml[k] = in_a[k];
                    mr[k] = in_b[k];
                end
            end
            OP_CROSS:
            begin
                ml[0] = in_a[1]; mr[0] = in_b[2];
                ml[1] = in_a[2]; mr[1] = in_b[1];
                ml[2] = in_a[2]; mr[2] = in_b[0];
                ml[3] = in_a[0]; mr[3] = in_b[2];
                ml[4] = in_a[0]; mr[4] = in_b[1];
                ml[5] = in_a[1]; mr[5] = in_b[0];
            end
            OP_MADD:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ml[k] = in_b[k];
                    mr[k] = in_f;
                end
            end
            default:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ml[k] = in_a[k];
                    mr[k] = in_a[k];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= in_op;
            for (int k = 0; k < 3; k++)
                a1_reg[k] <= in_a[k];
            for (int k = 0; k < 6; k++)
                p1_reg[k] <= ml[k] * mr[k];
        end
    end

    assign vec_op = (op1_reg == OP_CROSS) || (op1_reg == OP_MADD);

    always_comb
    begin
        sum = EW'(p1_reg[0]) + EW'(p1_reg[1]) + EW'(p1_reg[2]);
        for (int k = 0; k < 3; k++)
        begin
            case (op1_reg)
                OP_CROSS: pre[k] = EW'(p1_reg[2*k]) - EW'(p1_reg[2*k+1]);
                OP_MADD:  pre[k] = (EW'(a1_reg[k]) <<< FRAC_BITS) + EW'(p1_reg[k]);
                default:  pre[k] = '0;
            endcase
            // round to nearest, ties up
            rnd[k] = (pre[k] + HALF) >>> FRAC_BITS;
            hi[k]  = rnd[k] > MAXV;
            lo[k]  = rnd[k] < MINV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg   <= op1_reg;
            scal2_reg <= SCALAR_W'(sum);
            sq2_reg   <= SQ_W'(sum);
            sat2_reg  <= vec_op && (hi[0] || lo[0] || hi[1] || lo[1] || hi[2] || lo[2]);
            for (int k = 0; k < 3; k++)
            begin
                a2_reg[k] <= a1_reg[k];
                if (hi[k])
                    vec2_reg[k] <= MAXV[CW-1:0];
                else if (lo[k])
                    vec2_reg[k] <= MINV[CW-1:0];
                else
                    vec2_reg[k] <= rnd[k][CW-1:0];
            end
        end
    end

    assign out_valid  = v2_reg;
    assign out_op     = op2_reg;
    assign out_a      = a2_reg;
    assign out_vec    = vec2_reg;
    assign out_sat    = sat2_reg;
    assign out_scalar = scal2_reg;
    assign out_sq     = sq2_reg;

endmodule

[src/vec3_sqrt_cell.sv]
`timescale 1ns / 1ps
// one digit step of the scaled square root, registered
// no package dependencies
module vec3_sqrt_cell #(
    parameter int FRAC_BITS = 16,
    parameter int SQ_W      = 49,
    parameter int ROOT_W    = 48,
    parameter int SIDE_W    = 198,
    parameter int STEP      = 0
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SIDE_W-1:0]   in_side,
    input  logic [SQ_W-1:0]     in_sq,
    input  logic [ROOT_W-1:0]   in_root,
    input  logic [ROOT_W+1:0]   in_rem,
    output logic                out_valid,
    output logic [SIDE_W-1:0]   out_side,
    output logic [SQ_W-1:0]     out_sq,
    output logic [ROOT_W-1:0]   out_root,
    output logic [ROOT_W+1:0]   out_rem
);

    localparam int REM_W = ROOT_W + 2;
    localparam int BIT   = 2 * STEP - 2 * FRAC_BITS;
    localparam int BITS  = (BIT < 0) ? 0 : BIT;

    logic [1:0]       pair;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    logic              v_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;

    always_comb
    begin
        if (BIT >= 0 && BITS < SQ_W)
            pair = 2'(in_sq >> BITS);
        else
            pair = 2'b00;
        rem_sh = {in_rem[REM_W-3:0], pair};
        trial  = {in_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            sq_reg   <= in_sq;
            root_reg <= {in_root[ROOT_W-2:0], ge};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
        end
    end

    assign out_valid = v_reg;
    assign out_side  = side_reg;
    assign out_sq    = sq_reg;
    assign out_root  = root_reg;
    assign out_rem   = rem_reg;

endmodule

[src/vec3_div_cell.sv]
`timescale 1ns / 1ps
// one quotient bit of three restoring divisions by the length, registered
// no package dependencies
module vec3_div_cell #(
    parameter int ROOT_W = 48,
    parameter int QW     = 17,
    parameter int SIDE_W = 198
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SIDE_W-1:0]   in_side,
    input  logic [ROOT_W-1:0]   in_len,
    input  logic [ROOT_W:0]     in_r [3],
    input  logic [QW-1:0]       in_q [3],
    output logic                out_valid,
    output logic [SIDE_W-1:0]   out_side,
    output logic [ROOT_W-1:0]   out_len,
    output logic [ROOT_W:0]     out_r [3],
    output logic [QW-1:0]       out_q [3]
);

    localparam int RW = ROOT_W + 1;

    logic [RW-1:0] sh [3];
    logic          ge [3];

    logic              v_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [ROOT_W-1:0] len_reg;
    logic [RW-1:0]     r_reg [3];
    logic [QW-1:0]     q_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sh[k] = {in_r[k][RW-2:0], 1'b0};
            ge[k] = sh[k] >= {1'b0, in_len};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            len_reg  <= in_len;
            for (int k = 0; k < 3; k++)
            begin
                r_reg[k] <= ge[k] ? (sh[k] - {1'b0, in_len}) : sh[k];
                q_reg[k] <= {in_q[k][QW-2:0], ge[k]};
            end
        end
    end

    assign out_valid = v_reg;
    assign out_side  = side_reg;
    assign out_len   = len_reg;
    assign out_r     = r_reg;
    assign out_q     = q_reg;

endmodule
